>>> rtl/cmc_pkg.sv
// Shared types, constants and fixed-point helpers for the color model converter.
// Used by cmc_div and color_model_convert; depends on nothing else.
`default_nettype none

package cmc_pkg;

  typedef enum logic [2:0] {
    MODEL_GREY = 3'd0,
    MODEL_RGB  = 3'd1,
    MODEL_HSL  = 3'd2,
    MODEL_HSV  = 3'd3,
    MODEL_CMYK = 3'd4
  } model_t;

  typedef logic [24:0] q24_t;

  localparam q24_t        QONE       = 25'h100_0000;
  localparam logic [15:0] HUE_FULL   = 16'd36000;
  localparam logic [15:0] HUE_SECTOR = 16'd6000;
  // floor(2^40 / 375), used to form floor(rem * 2^24 / 6000).
  localparam logic [31:0] SEC_RECIP  = 32'd2932031007;
  localparam int          DIV_DEN_W  = 25;
  localparam int          DIV_QUO_W  = 16;

  // ceil(x * 2^24 / 65535)
  function automatic q24_t q_in(input logic [15:0] x);
    logic [24:0] y;
    logic [8:0]  qt;
    logic [16:0] rem;
    logic        corr;
    y    = {1'b0, x, 8'd0} + 25'd65534;
    qt   = y[24:16];
    rem  = {1'b0, y[15:0]} + {8'd0, qt};
    corr = (rem >= 17'd65535);
    return {1'b0, x, 8'd0} + {16'd0, qt} + {24'd0, corr};
  endfunction

  // floor(clamp(v, 0, 1) * 65535)
  function automatic logic [15:0] out16(input logic [26:0] v);
    logic [42:0] p;
    p = {v, 16'd0} - {16'd0, v};
    if (v >= {2'b0, QONE}) begin
      return 16'hFFFF;
    end
    return p[39:24];
  endfunction

  function automatic q24_t mulq(input q24_t a, input q24_t b);
    logic [49:0] p;
    p = a * b;
    return p[48:24];
  endfunction

  // n * 65535 as a divider numerator.
  function automatic logic [40:0] rnum(input q24_t n);
    return {n, 16'd0} - {16'd0, n};
  endfunction

endpackage

`default_nettype wire

>>> rtl/color_model_convert.sv
// From an accepted input word to out_tvalid, 10 front stages bring the pixel
// to rgb and form the operands, 16 divider stages resolve one quotient bit
// each, and one output register follows.
// Throughput: one word per cycle; the whole pipeline advances when the output
// register is empty or being taken.
// Reset (synchronous, rst_n low) clears all valid bits and sets the target to rgb.
`default_nettype none

module color_model_convert
  import cmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // src_model[2:0], chan_a[18:3], chan_b[34:19], chan_c[50:35], chan_d[66:51],
  // alpha_in[82:67], zero pad[87:83]
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_model[2:0], out_a[18:3], out_b[34:19], out_c[50:35], out_d[66:51],
  // out_alpha[82:67], zero pad[87:83]
  output logic      [87:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data
);

  localparam int FRONT_N = 10;
  localparam int DIV_LAT = DIV_QUO_W;
  localparam int PIPE_N  = FRONT_N + DIV_LAT;

  typedef struct packed {
    logic             same;
    logic [2:0][15:0] rgb;
    logic [15:0]      chd;
    logic [15:0]      alpha;
    logic [7:0]       grey;
    logic [15:0]      light;
    logic [15:0]      key;
    logic [15:0]      val;
    logic [2:0]       zero;
    logic [2:0]       sat;
  } side_t;

  logic [2:0] target_r;
  model_t     tgt;
  logic       en;
  logic       vld_r [PIPE_N];
  logic       out_valid_r;
  logic [87:0] out_data_r;

  assign cfg_ready = 1'b1;
  assign tgt = (target_r > 3'd4) ? MODEL_RGB : model_t'(target_r);
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      target_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_N; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < PIPE_N; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[PIPE_N-1];
    end
  end

  // Stage 1: unpack, hue sector, channel scaling.
  logic [2:0]  i_src;
  logic [15:0] i_ch [4];
  logic [15:0] i_hue;
  logic [2:0]  i_sec;
  logic [15:0] i_base;
  model_t      s1_src_r;
  logic        s1_same_r;
  logic [15:0] s1_ch_r [4];
  logic [15:0] s1_alpha_r;
  logic [2:0]  s1_sec_r;
  logic [12:0] s1_hrem_r;
  q24_t        s1_q_r [4];

  always_comb begin
    i_src = in_tdata[2:0];
    for (int i = 0; i < 4; i++) i_ch[i] = in_tdata[3+16*i +: 16];
    i_hue = (i_ch[0] >= HUE_FULL) ? 16'd0 : i_ch[0];
    priority if (i_hue < HUE_SECTOR) begin
      i_sec = 3'd0; i_base = 16'd0;
    end else if (i_hue < 16'd12000) begin
      i_sec = 3'd1; i_base = HUE_SECTOR;
    end else if (i_hue < 16'd18000) begin
      i_sec = 3'd2; i_base = 16'd12000;
    end else if (i_hue < 16'd24000) begin
      i_sec = 3'd3; i_base = 16'd18000;
    end else if (i_hue < 16'd30000) begin
      i_sec = 3'd4; i_base = 16'd24000;
    end else begin
      i_sec = 3'd5; i_base = 16'd30000;
    end
  end

  logic [15:0] i_hrem;
  assign i_hrem = i_hue - i_base;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_src_r   <= (i_src > 3'd4) ? MODEL_RGB : model_t'(i_src);
      s1_same_r  <= (i_src == tgt);
      s1_alpha_r <= in_tdata[82:67];
      s1_sec_r   <= i_sec;
      s1_hrem_r  <= i_hrem[12:0];
      for (int i = 0; i < 4; i++) begin
        s1_ch_r[i] <= i_ch[i];
        s1_q_r[i]  <= q_in(i_ch[i]);
      end
    end
  end

  // Stage 2: first products.
  logic [44:0] f0_prod;
  logic [25:0] l2;
  logic [25:0] tt;
  model_t      s2_src_r;
  logic        s2_same_r;
  logic [15:0] s2_ch_r [4];
  logic [15:0] s2_alpha_r;
  logic [2:0]  s2_sec_r;
  logic [12:0] s2_hrem_r;
  q24_t        s2_s_r, s2_l_r, s2_k_r, s2_f0_r, s2_c_r, s2_p_r;
  q24_t        s2_pc_r [3];

  assign f0_prod = {32'd0, s1_hrem_r} * {13'd0, SEC_RECIP};
  assign l2 = {s1_q_r[2], 1'b0};
  assign tt = (l2 >= {1'b0, QONE}) ? l2 - {1'b0, QONE} : {1'b0, QONE} - l2;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_src_r   <= s1_src_r;
      s2_same_r  <= s1_same_r;
      s2_ch_r    <= s1_ch_r;
      s2_alpha_r <= s1_alpha_r;
      s2_sec_r   <= s1_sec_r;
      s2_hrem_r  <= s1_hrem_r;
      s2_s_r     <= s1_q_r[1];
      s2_l_r     <= s1_q_r[2];
      s2_k_r     <= s1_q_r[3];
      s2_f0_r    <= f0_prod[44:20];
      s2_c_r     <= mulq(QONE - tt[24:0], s1_q_r[1]);
      s2_p_r     <= mulq(s1_q_r[2], QONE - s1_q_r[1]);
      for (int i = 0; i < 3; i++) s2_pc_r[i] <= mulq(s1_q_r[i], QONE - s1_q_r[3]);
    end
  end

  // Stage 3: correct the sector position estimate.
  logic [32:0] f_chk;
  model_t      s3_src_r;
  logic        s3_same_r;
  logic [15:0] s3_ch_r [4];
  logic [15:0] s3_alpha_r;
  logic [2:0]  s3_sec_r;
  q24_t        s3_s_r, s3_l_r, s3_k_r, s3_f_r, s3_c_r, s3_p_r;
  q24_t        s3_pc_r [3];

  assign f_chk = {s2_hrem_r, 20'd0} - ({8'd0, s2_f0_r} * 33'd375);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_src_r   <= s2_src_r;
      s3_same_r  <= s2_same_r;
      s3_ch_r    <= s2_ch_r;
      s3_alpha_r <= s2_alpha_r;
      s3_sec_r   <= s2_sec_r;
      s3_s_r     <= s2_s_r;
      s3_l_r     <= s2_l_r;
      s3_k_r     <= s2_k_r;
      s3_f_r     <= s2_f0_r + {24'd0, (f_chk >= 33'd375)};
      s3_c_r     <= s2_c_r;
      s3_p_r     <= s2_p_r;
      s3_pc_r    <= s2_pc_r;
    end
  end

  // Stage 4: products with the sector position.
  model_t      s4_src_r;
  logic        s4_same_r;
  logic [15:0] s4_ch_r [4];
  logic [15:0] s4_alpha_r;
  logic [2:0]  s4_sec_r;
  q24_t        s4_l_r, s4_k_r, s4_c_r, s4_p_r, s4_sf_r, s4_sg_r, s4_x_r;
  q24_t        s4_pc_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s4_src_r   <= s3_src_r;
      s4_same_r  <= s3_same_r;
      s4_ch_r    <= s3_ch_r;
      s4_alpha_r <= s3_alpha_r;
      s4_sec_r   <= s3_sec_r;
      s4_l_r     <= s3_l_r;
      s4_k_r     <= s3_k_r;
      s4_c_r     <= s3_c_r;
      s4_p_r     <= s3_p_r;
      s4_pc_r    <= s3_pc_r;
      s4_sf_r    <= mulq(s3_s_r, s3_f_r);
      s4_sg_r    <= mulq(s3_s_r, QONE - s3_f_r);
      s4_x_r     <= mulq(s3_c_r, s3_sec_r[0] ? QONE - s3_f_r : s3_f_r);
    end
  end

  // Stage 5: remaining hsv products.
  model_t      s5_src_r;
  logic        s5_same_r;
  logic [15:0] s5_ch_r [4];
  logic [15:0] s5_alpha_r;
  logic [2:0]  s5_sec_r;
  q24_t        s5_l_r, s5_k_r, s5_c_r, s5_p_r, s5_x_r, s5_q_r, s5_t_r;
  q24_t        s5_pc_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s5_src_r   <= s4_src_r;
      s5_same_r  <= s4_same_r;
      s5_ch_r    <= s4_ch_r;
      s5_alpha_r <= s4_alpha_r;
      s5_sec_r   <= s4_sec_r;
      s5_l_r     <= s4_l_r;
      s5_k_r     <= s4_k_r;
      s5_c_r     <= s4_c_r;
      s5_p_r     <= s4_p_r;
      s5_x_r     <= s4_x_r;
      s5_pc_r    <= s4_pc_r;
      s5_q_r     <= mulq(s4_l_r, QONE - s4_sf_r);
      s5_t_r     <= mulq(s4_l_r, QONE - s4_sg_r);
    end
  end

  // Stage 6: assemble 16-bit rgb.
  logic [25:0] hm;
  logic [25:0] hb [3];
  q24_t        hv [3];
  logic [26:0] vsel [3];
  logic [15:0] rgb6 [3];
  logic [15:0] alpha6;
  logic        s6_same_r;
  logic [15:0] s6_rgb_r [3];
  logic [15:0] s6_d_r;
  logic [15:0] s6_alpha_r;

  always_comb begin
    hm = {1'b0, s5_l_r} - {2'b0, s5_c_r[24:1]};
    unique case (s5_sec_r)
      3'd0: begin
        hb[0] = {1'b0, s5_c_r}; hb[1] = {1'b0, s5_x_r}; hb[2] = '0;
        hv[0] = s5_l_r; hv[1] = s5_t_r; hv[2] = s5_p_r;
      end
      3'd1: begin
        hb[0] = {1'b0, s5_x_r}; hb[1] = {1'b0, s5_c_r}; hb[2] = '0;
        hv[0] = s5_q_r; hv[1] = s5_l_r; hv[2] = s5_p_r;
      end
      3'd2: begin
        hb[0] = '0; hb[1] = {1'b0, s5_c_r}; hb[2] = {1'b0, s5_x_r};
        hv[0] = s5_p_r; hv[1] = s5_l_r; hv[2] = s5_t_r;
      end
      3'd3: begin
        hb[0] = '0; hb[1] = {1'b0, s5_x_r}; hb[2] = {1'b0, s5_c_r};
        hv[0] = s5_p_r; hv[1] = s5_q_r; hv[2] = s5_l_r;
      end
      3'd4: begin
        hb[0] = {1'b0, s5_x_r}; hb[1] = '0; hb[2] = {1'b0, s5_c_r};
        hv[0] = s5_t_r; hv[1] = s5_p_r; hv[2] = s5_l_r;
      end
      default: begin
        hb[0] = {1'b0, s5_c_r}; hb[1] = '0; hb[2] = {1'b0, s5_x_r};
        hv[0] = s5_l_r; hv[1] = s5_p_r; hv[2] = s5_q_r;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      unique case (s5_src_r)
        MODEL_HSL: vsel[i] = {1'b0, hb[i]} + {1'b0, hm};
        MODEL_HSV: vsel[i] = {2'b0, hv[i]};
        default:   vsel[i] = {2'b0, QONE - s5_pc_r[i] - s5_k_r};
      endcase
    end
    alpha6 = s5_alpha_r;
    if (s5_same_r) begin
      for (int i = 0; i < 3; i++) rgb6[i] = s5_ch_r[i];
    end else begin
      unique case (s5_src_r)
        MODEL_GREY: begin
          for (int i = 0; i < 3; i++) rgb6[i] = {s5_ch_r[0][15:8], s5_ch_r[0][15:8]};
          alpha6 = {s5_alpha_r[15:8], s5_alpha_r[15:8]};
        end
        MODEL_HSL, MODEL_HSV, MODEL_CMYK: begin
          for (int i = 0; i < 3; i++) rgb6[i] = out16(vsel[i]);
        end
        default: begin
          for (int i = 0; i < 3; i++) rgb6[i] = s5_ch_r[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_same_r  <= s5_same_r;
      s6_rgb_r   <= rgb6;
      s6_d_r     <= s5_ch_r[3];
      s6_alpha_r <= alpha6;
    end
  end

  // Stage 7: grey average and rescaling of rgb.
  logic [9:0]  gsum;
  logic [20:0] gprod;
  logic        s7_same_r;
  logic [15:0] s7_rgb_r [3];
  logic [15:0] s7_d_r;
  logic [15:0] s7_alpha_r;
  logic [7:0]  s7_grey_r;
  q24_t        s7_q_r [3];

  assign gsum = {2'b0, s6_rgb_r[0][15:8]} + {2'b0, s6_rgb_r[1][15:8]}
              + {2'b0, s6_rgb_r[2][15:8]};
  assign gprod = {11'd0, gsum} * 21'd683;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_same_r  <= s6_same_r;
      s7_rgb_r   <= s6_rgb_r;
      s7_d_r     <= s6_d_r;
      s7_alpha_r <= s6_alpha_r;
      s7_grey_r  <= gprod[18:11];
      for (int i = 0; i < 3; i++) s7_q_r[i] <= q_in(s6_rgb_r[i]);
    end
  end

  // Stage 8: extremes.
  q24_t        cmax8, cmin8, mx_rg, mn_rg;
  logic        s8_same_r;
  logic [15:0] s8_rgb_r [3];
  logic [15:0] s8_d_r;
  logic [15:0] s8_alpha_r;
  logic [7:0]  s8_grey_r;
  q24_t        s8_q_r [3];
  q24_t        s8_cmax_r, s8_delta_r;
  logic [25:0] s8_sum_r;
  logic        s8_rmax_r, s8_gmax_r;

  assign mx_rg = (s7_q_r[0] > s7_q_r[1]) ? s7_q_r[0] : s7_q_r[1];
  assign mn_rg = (s7_q_r[0] < s7_q_r[1]) ? s7_q_r[0] : s7_q_r[1];
  assign cmax8 = (s7_q_r[2] > mx_rg) ? s7_q_r[2] : mx_rg;
  assign cmin8 = (s7_q_r[2] < mn_rg) ? s7_q_r[2] : mn_rg;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_same_r  <= s7_same_r;
      s8_rgb_r   <= s7_rgb_r;
      s8_d_r     <= s7_d_r;
      s8_alpha_r <= s7_alpha_r;
      s8_grey_r  <= s7_grey_r;
      s8_q_r     <= s7_q_r;
      s8_cmax_r  <= cmax8;
      s8_delta_r <= cmax8 - cmin8;
      s8_sum_r   <= {1'b0, cmax8} + {1'b0, cmin8};
      s8_rmax_r  <= (s7_q_r[0] == cmax8);
      s8_gmax_r  <= (s7_q_r[1] == cmax8);
    end
  end

  // Stage 9: hue numerator and ratio operands.
  logic signed [27:0] sr, sg, sb, sdl, xa, xw;
  logic [41:0] lp;
  q24_t        ik9, n0_9, d0_9;
  logic        s9_same_r;
  logic [15:0] s9_rgb_r [3];
  logic [15:0] s9_d_r;
  logic [15:0] s9_alpha_r;
  logic [7:0]  s9_grey_r;
  logic [15:0] s9_light_r, s9_key_r, s9_val_r;
  logic [26:0] s9_x_r;
  q24_t        s9_delta_r, s9_n0_r, s9_d0_r, s9_n1_r, s9_n2_r, s9_ik_r;

  always_comb begin
    sr  = $signed({3'b0, s8_q_r[0]});
    sg  = $signed({3'b0, s8_q_r[1]});
    sb  = $signed({3'b0, s8_q_r[2]});
    sdl = $signed({3'b0, s8_delta_r});
    priority if (s8_rmax_r) begin
      xa = sg - sb;
    end else if (s8_gmax_r) begin
      xa = (sdl <<< 1) + sb - sr;
    end else begin
      xa = (sdl <<< 2) + sr - sg;
    end
    xw = (xa < 0) ? xa + (sdl <<< 2) + (sdl <<< 1) : xa;
    lp = {s8_sum_r, 16'd0} - {16'd0, s8_sum_r};
    ik9 = (s8_cmax_r == '0) ? QONE : s8_cmax_r;
    unique case (tgt)
      MODEL_CMYK: begin
        n0_9 = s8_cmax_r - s8_q_r[0];
        d0_9 = ik9;
      end
      MODEL_HSL: begin
        n0_9 = s8_delta_r;
        d0_9 = (s8_sum_r < {1'b0, QONE}) ? s8_sum_r[24:0]
                                          : QONE - (s8_sum_r[24:0] - QONE);
      end
      default: begin
        n0_9 = s8_delta_r;
        d0_9 = s8_cmax_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_same_r  <= s8_same_r;
      s9_rgb_r   <= s8_rgb_r;
      s9_d_r     <= s8_d_r;
      s9_alpha_r <= s8_alpha_r;
      s9_grey_r  <= s8_grey_r;
      s9_light_r <= (s8_sum_r >= {QONE, 1'b0}) ? 16'hFFFF : lp[40:25];
      s9_key_r   <= out16({2'b0, QONE - s8_cmax_r});
      s9_val_r   <= out16({2'b0, s8_cmax_r});
      s9_x_r     <= xw[26:0];
      s9_delta_r <= s8_delta_r;
      s9_n0_r    <= n0_9;
      s9_d0_r    <= d0_9;
      s9_n1_r    <= s8_cmax_r - s8_q_r[1];
      s9_n2_r    <= s8_cmax_r - s8_q_r[2];
      s9_ik_r    <= ik9;
    end
  end

  // Stage 10: divider numerators and special-case flags.
  logic        cmyk10;
  side_t       side10;
  side_t       side_r [DIV_LAT+1];
  logic [40:0] s10_num_r [3];
  q24_t        s10_den_r [3];
  logic [15:0] quo [3];

  assign cmyk10 = (tgt == MODEL_CMYK);

  always_comb begin
    side10.same  = s9_same_r;
    for (int i = 0; i < 3; i++) side10.rgb[i] = s9_rgb_r[i];
    side10.chd   = s9_d_r;
    side10.alpha = s9_alpha_r;
    side10.grey  = s9_grey_r;
    side10.light = s9_light_r;
    side10.key   = s9_key_r;
    side10.val   = s9_val_r;
    side10.zero[0] = (s9_n0_r == '0) || (s9_d0_r == '0);
    side10.sat[0]  = (s9_n0_r >= s9_d0_r);
    side10.zero[1] = cmyk10 ? ((s9_n1_r == '0) || (s9_ik_r == '0))
                            : ((s9_x_r == '0) || (s9_delta_r == '0));
    side10.sat[1]  = cmyk10 && (s9_n1_r >= s9_ik_r);
    side10.zero[2] = (s9_n2_r == '0) || (s9_ik_r == '0);
    side10.sat[2]  = (s9_n2_r >= s9_ik_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0]    <= side10;
      s10_num_r[0] <= rnum(s9_n0_r);
      s10_den_r[0] <= s9_d0_r;
      s10_num_r[1] <= cmyk10 ? rnum(s9_n1_r) : {14'd0, s9_x_r} * 41'd6000;
      s10_den_r[1] <= cmyk10 ? s9_ik_r : s9_delta_r;
      s10_num_r[2] <= rnum(s9_n2_r);
      s10_den_r[2] <= s9_ik_r;
      for (int i = 1; i < DIV_LAT + 1; i++) side_r[i] <= side_r[i-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    cmc_div #(
      .DEN_W(DIV_DEN_W),
      .QUO_W(DIV_QUO_W)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (s10_num_r[k]),
      .den (s10_den_r[k]),
      .quo (quo[k])
    );
  end

  // Output register.
  side_t       sd;
  logic [15:0] res [3];
  logic [15:0] o_a, o_b, o_c, o_d, o_alpha;

  assign sd = side_r[DIV_LAT];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = sd.zero[i] ? 16'd0 : (sd.sat[i] ? 16'hFFFF : quo[i]);
    end
    o_a = 16'd0;
    o_b = 16'd0;
    o_c = 16'd0;
    o_d = 16'd0;
    o_alpha = sd.alpha;
    if (sd.same) begin
      o_a = sd.rgb[0];
      if (tgt != MODEL_GREY) begin
        o_b = sd.rgb[1];
        o_c = sd.rgb[2];
      end
      if (tgt == MODEL_CMYK) begin
        o_d = sd.chd;
      end
    end else begin
      unique case (tgt)
        MODEL_GREY: begin
          o_a = {sd.grey, sd.grey};
          o_alpha = {sd.alpha[15:8], sd.alpha[15:8]};
        end
        MODEL_CMYK: begin
          o_a = res[0];
          o_b = res[1];
          o_c = res[2];
          o_d = sd.key;
        end
        MODEL_HSL: begin
          o_a = res[1];
          o_b = res[0];
          o_c = sd.light;
        end
        MODEL_HSV: begin
          o_a = res[1];
          o_b = res[0];
          o_c = sd.val;
        end
        default: begin
          o_a = sd.rgb[0];
          o_b = sd.rgb[1];
          o_c = sd.rgb[2];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {5'd0, o_alpha, o_d, o_c, o_b, o_a, tgt};
    end
  end

`ifndef SYNTH
  a_out_model: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] == tgt))
    else $error("output word carries a model other than the target");

  a_grey_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (tgt == MODEL_GREY)) |-> (out_tdata[66:19] == '0))
    else $error("grey output word has nonzero unused channels");
`endif

endmodule

`default_nettype wire

>>> rtl/cmc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Uses cmc_pkg for its default widths; the caller keeps valid bits alongside.
`default_nettype none

module cmc_div
  import cmc_pkg::*;
#(
  parameter int DEN_W = DIV_DEN_W,
  parameter int QUO_W = DIV_QUO_W
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [DEN_W+QUO_W-1:0] num,
  input  wire logic [DEN_W-1:0]       den,
  output logic      [QUO_W-1:0]       quo
);

  localparam int NUM_W = DEN_W + QUO_W;

  logic [DEN_W-1:0] rem_in [QUO_W];
  logic [QUO_W-1:0] low_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic [DEN_W-1:0] den_in [QUO_W];
  logic [DEN_W-1:0] rem_r  [QUO_W-1];
  logic [QUO_W-1:0] low_r  [QUO_W-1];
  logic [DEN_W-1:0] den_r  [QUO_W-1];
  logic [QUO_W-1:0] quo_r  [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [DEN_W:0] sh;
    logic           ge;

    if (s == 0) begin : g_first
      assign rem_in[s] = num[NUM_W-1:QUO_W];
      assign low_in[s] = num[QUO_W-1:0];
      assign quo_in[s] = '0;
      assign den_in[s] = den;
    end else begin : g_next
      assign rem_in[s] = rem_r[s-1];
      assign low_in[s] = low_r[s-1];
      assign quo_in[s] = quo_r[s-1];
      assign den_in[s] = den_r[s-1];
    end

    assign sh = {rem_in[s], low_in[s][QUO_W-1]};
    assign ge = (sh >= {1'b0, den_in[s]});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= {quo_in[s][QUO_W-2:0], ge};
      end
    end

    if (s < QUO_W - 1) begin : g_carry
      logic [DEN_W:0] diff;
      assign diff = sh - {1'b0, den_in[s]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
          low_r[s] <= {low_in[s][QUO_W-2:0], 1'b0};
          den_r[s] <= den_in[s];
        end
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

`default_nettype wire
